### rtl/dhpp_pkg.sv
// Shared types, codes and character helpers of the delimited hex packet parser.
package dhpp_pkg;

   localparam logic [7:0] DELIM_CHAR  = 8'h7C;
   localparam logic [2:0] FIELD_LAST  = 3'd6;
   localparam logic [2:0] FIELD_MAX   = 3'd7;
   localparam logic [2:0] MAGIC_LEN   = 3'd5;
   localparam logic [2:0] MAGIC_SAT   = 3'd6;
   localparam logic [31:0] FLAGS_MAX  = 32'h0000_00FF;

   // result kinds
   localparam logic [1:0] KIND_SRC     = 2'd0;
   localparam logic [1:0] KIND_DST     = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_SUMMARY = 2'd3;

   // summary status codes, in check order
   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_FIELDS  = 3'd1;
   localparam logic [2:0] STATUS_MAGIC   = 3'd2;
   localparam logic [2:0] STATUS_TYPELEN = 3'd3;
   localparam logic [2:0] STATUS_ID      = 3'd4;
   localparam logic [2:0] STATUS_FLAGS   = 3'd5;
   localparam logic [2:0] STATUS_PAYLOAD = 3'd6;

   // output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [7:0]  out_byte;
      logic [7:0]  msg_type;
      logic [31:0] msg_id;
      logic [7:0]  msg_flags;
      logic [2:0]  status;
      logic        last;
   } dhpp_result_type;

   // up to two results per character: data first, then summary
   typedef struct packed {
      logic            first_valid;
      dhpp_result_type first;
      logic            second_valid;
      dhpp_result_type second;
   } dhpp_push_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] nib;
   } dhpp_hex_type;

   function automatic dhpp_hex_type hex_decode(input logic [7:0] c);
      dhpp_hex_type h;
      h.ok  = 1'b1;
      h.nib = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.nib = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.nib = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.nib = 4'(c - 8'h37);
      end else begin
         h.ok = 1'b0;
      end
      return h;
   endfunction

   // magic word CP2P1
   function automatic logic [7:0] magic_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = 8'h43;
         3'd1: c = 8'h50;
         3'd2: c = 8'h32;
         3'd3: c = 8'h50;
         3'd4: c = 8'h31;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

### rtl/dhpp_parse.sv
// Parser state and the per-character update that yields up to two results.
module dhpp_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [7:0]             rx_byte,
   input  logic                   end_of_packet,
   output dhpp_pkg::dhpp_push_type push
);

   typedef struct packed {
      logic [31:0] value;
      logic [2:0]  f;      // seen, stopped, overflow
   } num_type;

   function automatic num_type take_digit(input logic [31:0] value, input logic [2:0] f,
                                          input dhpp_pkg::dhpp_hex_type h);
      num_type r;
      r.value = value;
      r.f     = f;
      if (!f[1]) begin
         if (!h.ok) begin
            r.f[1] = 1'b1;
         end else begin
            r.f[0] = 1'b1;
            if (value[31:28] != 4'd0) r.f[2] = 1'b1;
            if (!r.f[2]) r.value = {value[27:0], h.nib};
         end
      end
      return r;
   endfunction

   logic [2:0]  field_ff, field_in;
   logic [2:0]  mpos_ff, mpos_in;
   logic        mbad_ff, mbad_in;
   logic [1:0]  tlen_ff, tlen_in;
   logic [7:0]  tchar_ff, tchar_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] flags_ff, flags_in;
   logic [5:0]  nflags_ff, nflags_in;
   logic [3:0]  hi_ff, hi_in;
   logic        odd_ff, odd_in;
   logic        pbad_ff, pbad_in;

   dhpp_pkg::dhpp_hex_type hex;
   num_type                num;
   logic [3:0]             nib;
   logic [2:0]             status;

   always_comb begin
      hex       = dhpp_pkg::hex_decode(rx_byte);
      field_in  = field_ff;
      mpos_in   = mpos_ff;
      mbad_in   = mbad_ff;
      tlen_in   = tlen_ff;
      tchar_in  = tchar_ff;
      id_in     = id_ff;
      flags_in  = flags_ff;
      nflags_in = nflags_ff;
      hi_in     = hi_ff;
      odd_in    = odd_ff;
      pbad_in   = pbad_ff;
      num       = '0;
      nib       = hex.ok ? hex.nib : 4'd0;
      status    = dhpp_pkg::STATUS_OK;
      push      = '0;

      if (rx_byte == dhpp_pkg::DELIM_CHAR) begin
         if (field_ff < dhpp_pkg::FIELD_MAX) field_in = field_ff + 3'd1;
      end else begin
         unique case (field_ff)
            3'd0: begin
               if (mpos_ff >= dhpp_pkg::MAGIC_LEN || dhpp_pkg::magic_char(mpos_ff) != rx_byte)
                  mbad_in = 1'b1;
               if (mpos_ff < dhpp_pkg::MAGIC_SAT) mpos_in = mpos_ff + 3'd1;
            end
            3'd1: begin
               if (tlen_ff == 2'd0) tchar_in = rx_byte;
               if (tlen_ff < 2'd2) tlen_in = tlen_ff + 2'd1;
            end
            3'd2: begin
               push.first_valid       = 1'b1;
               push.first.out_kind    = dhpp_pkg::KIND_SRC;
               push.first.out_byte    = rx_byte;
            end
            3'd3: begin
               push.first_valid       = 1'b1;
               push.first.out_kind    = dhpp_pkg::KIND_DST;
               push.first.out_byte    = rx_byte;
            end
            3'd4: begin
               num            = take_digit(id_ff, nflags_ff[2:0], hex);
               id_in          = num.value;
               nflags_in[2:0] = num.f;
            end
            3'd5: begin
               num            = take_digit(flags_ff, nflags_ff[5:3], hex);
               flags_in       = num.value;
               nflags_in[5:3] = num.f;
            end
            3'd6: begin
               if (!hex.ok) pbad_in = 1'b1;
               if (!odd_ff) begin
                  hi_in  = nib;
                  odd_in = 1'b1;
               end else begin
                  push.first_valid    = 1'b1;
                  push.first.out_kind = dhpp_pkg::KIND_PAYLOAD;
                  push.first.out_byte = {hi_ff, nib};
                  odd_in              = 1'b0;
               end
            end
            default: begin
               // characters past the seventh field are dropped
            end
         endcase
      end

      if (end_of_packet) begin
         priority if (field_in != dhpp_pkg::FIELD_LAST)
            status = dhpp_pkg::STATUS_FIELDS;
         else if (mbad_in || mpos_in != dhpp_pkg::MAGIC_LEN)
            status = dhpp_pkg::STATUS_MAGIC;
         else if (tlen_in != 2'd1)
            status = dhpp_pkg::STATUS_TYPELEN;
         else if (!nflags_in[0] || nflags_in[2])
            status = dhpp_pkg::STATUS_ID;
         else if (!nflags_in[3] || nflags_in[5] || flags_in > dhpp_pkg::FLAGS_MAX)
            status = dhpp_pkg::STATUS_FLAGS;
         else if (pbad_in || odd_in)
            status = dhpp_pkg::STATUS_PAYLOAD;
         else
            status = dhpp_pkg::STATUS_OK;

         push.second_valid       = 1'b1;
         push.second.out_kind    = dhpp_pkg::KIND_SUMMARY;
         push.second.status      = status;
         push.second.last        = 1'b1;
         if (status == dhpp_pkg::STATUS_OK) begin
            push.second.msg_type  = tchar_in;
            push.second.msg_id    = id_in;
            push.second.msg_flags = flags_in[7:0];
         end

         field_in  = '0;
         mpos_in   = '0;
         mbad_in   = 1'b0;
         tlen_in   = '0;
         tchar_in  = '0;
         id_in     = '0;
         flags_in  = '0;
         nflags_in = '0;
         hi_in     = '0;
         odd_in    = 1'b0;
         pbad_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff  <= '0;
         mpos_ff   <= '0;
         mbad_ff   <= 1'b0;
         tlen_ff   <= '0;
         tchar_ff  <= '0;
         id_ff     <= '0;
         flags_ff  <= '0;
         nflags_ff <= '0;
         hi_ff     <= '0;
         odd_ff    <= 1'b0;
         pbad_ff   <= 1'b0;
      end else if (go) begin
         field_ff  <= field_in;
         mpos_ff   <= mpos_in;
         mbad_ff   <= mbad_in;
         tlen_ff   <= tlen_in;
         tchar_ff  <= tchar_in;
         id_ff     <= id_in;
         flags_ff  <= flags_in;
         nflags_ff <= nflags_in;
         hi_ff     <= hi_in;
         odd_ff    <= odd_in;
         pbad_ff   <= pbad_in;
      end
   end

endmodule

### rtl/dhpp_queue.sv
// Small result queue: takes up to two results a cycle, hands out one at the head.
module dhpp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  dhpp_pkg::dhpp_push_type   push,
   output logic                      room,
   output logic                      out_valid,
   input  logic                      out_stall,
   output dhpp_pkg::dhpp_result_type out_data
);

   localparam int QD = dhpp_pkg::QUEUE_DEPTH;
   localparam int CW = dhpp_pkg::QCOUNT_W;

   dhpp_pkg::dhpp_result_type entry_ff [QD];
   dhpp_pkg::dhpp_result_type entry_in [QD];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] base;
   logic [CW-1:0] base2;
   logic          pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[0];
   // two free slots needed, a packet end can bring two results
   assign room      = (count_ff <= CW'(QD - 2));
   assign pop       = out_valid && !out_stall;

   always_comb begin
      for (int i = 0; i < QD; i++) begin
         entry_in[i] = entry_ff[i];
      end
      if (pop) begin
         for (int i = 0; i < QD - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
      end
      base  = count_ff - CW'(pop);
      base2 = base + CW'(push.first_valid);
      for (int i = 0; i < QD; i++) begin
         if (push.first_valid && base == CW'(i))   entry_in[i] = push.first;
         if (push.second_valid && base2 == CW'(i)) entry_in[i] = push.second;
      end
      count_in = base2 + CW'(push.second_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QD; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

### rtl/delimited_hex_packet_parser_unit.sv
// Top level of the delimited hex packet parser: input register, parser and result queue.
//
//   channel   dir   handshake              beat
//   req_      in    req_valid/req_stall    one packet character, end-of-packet mark
//   rsp_      out   rsp_valid/rsp_stall    address byte, payload byte or packet summary
//
// Characters are registered on entry and parsed, one per cycle while the queue has room.
// Results are written into a four-entry queue and reach rsp_ from its registered head.
// The final character of a packet may emit a data beat and a summary; the queue takes
// both and the summary leaves behind the data beat, so req_stall stays low unless rsp_stall holds.
// reset clears parser state and empties the queue.
// rsp_stall backs up the queue; req_stall follows once fewer than two slots are free.
module delimited_hex_packet_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_packet,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_out_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [7:0]  rsp_msg_type,
   output logic [31:0] rsp_msg_id,
   output logic [7:0]  rsp_msg_flags,
   output logic [2:0]  rsp_status,
   output logic        rsp_last
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eop_ff;
   logic       room;
   logic       advance;
   logic       accept;

   dhpp_pkg::dhpp_push_type   push;
   dhpp_pkg::dhpp_result_type head;

   assign advance     = in_valid_ff && room;
   assign req_stall   = in_valid_ff && !room;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_rx_byte;
         in_eop_ff  <= req_end_of_packet;
      end
   end

   dhpp_parse u_parse (
      .clock         (clock),
      .reset         (reset),
      .go            (advance),
      .rx_byte       (in_byte_ff),
      .end_of_packet (in_eop_ff),
      .push          (push)
   );

   dhpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (advance ? push : '0),
      .room      (room),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (head)
   );

   assign rsp_out_kind  = head.out_kind;
   assign rsp_out_byte  = head.out_byte;
   assign rsp_msg_type  = head.msg_type;
   assign rsp_msg_id    = head.msg_id;
   assign rsp_msg_flags = head.msg_flags;
   assign rsp_status    = head.status;
   assign rsp_last      = head.last;

   // queue comes out of reset empty
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present after reset");

   a_last_is_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_out_kind == dhpp_pkg::KIND_SUMMARY)))
      else $error("last flag and summary kind disagree");

   a_data_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == dhpp_pkg::STATUS_OK && rsp_msg_id == '0))
      else $error("data beat carries summary fields");

   a_bad_summary_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != dhpp_pkg::STATUS_OK) |->
      (rsp_msg_id == '0 && rsp_msg_type == '0 && rsp_msg_flags == '0))
      else $error("failed summary carries parsed values");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench of the delimited hex packet parser: edge packets, random packets, idling and stalling phases.
`timescale 1ns / 100ps

module testbench;

   typedef struct packed {
      logic [7:0] ch;
      logic       eop;
   } rx_char_type;

   // field positions within a packet
   localparam logic [2:0] FLD_MAGIC   = 3'd0;
   localparam logic [2:0] FLD_TYPE    = 3'd1;
   localparam logic [2:0] FLD_SRC     = 3'd2;
   localparam logic [2:0] FLD_DST     = 3'd3;
   localparam logic [2:0] FLD_ID      = 3'd4;
   localparam logic [2:0] FLD_FLAGS   = 3'd5;
   localparam logic [2:0] FLD_PAYLOAD = 3'd6;

   localparam logic [39:0] MAGIC_WORD = "CP2P1";

   // packet damage applied by the generator
   localparam int FAULT_NONE        = 0;
   localparam int FAULT_FIELDS_FEW  = 1;
   localparam int FAULT_FIELDS_MANY = 2;
   localparam int FAULT_MAGIC       = 3;
   localparam int FAULT_TYPE        = 4;
   localparam int FAULT_ID_EMPTY    = 5;
   localparam int FAULT_ID_OVERFLOW = 6;
   localparam int FAULT_FLAGS_BIG   = 7;
   localparam int FAULT_FLAGS_EMPTY = 8;
   localparam int FAULT_PAYLOAD_ODD = 9;
   localparam int FAULT_PAYLOAD_BAD = 10;
   localparam int FAULT_NOISE       = 11;
   localparam int FAULT_EARLY_EOP   = 12;

   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_end_of_packet = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_out_kind;
   logic [7:0]  rsp_out_byte;
   logic [7:0]  rsp_msg_type;
   logic [31:0] rsp_msg_id;
   logic [7:0]  rsp_msg_flags;
   logic [2:0]  rsp_status;
   logic        rsp_last;

   delimited_hex_packet_parser_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .req_end_of_packet (req_end_of_packet),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_msg_type      (rsp_msg_type),
      .rsp_msg_id        (rsp_msg_id),
      .rsp_msg_flags     (rsp_msg_flags),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   rx_char_type               char_queue[$];
   logic [7:0]                packet_chars[$];
   dhpp_pkg::dhpp_result_type expected_beats[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_requests      = 0;
   int holds_served       = 0;
   int hold_left          = 0;
   int mismatch_count     = 0;
   int quiet_cycles       = 0;

   // parser state as predicted
   logic [2:0]  field_num;
   logic [2:0]  magic_pos;
   logic        magic_bad;
   logic [1:0]  type_len;
   logic [7:0]  type_ch;
   logic [31:0] id_val;
   logic [31:0] flg_val;
   logic        id_seen, id_stop, id_ovf;
   logic        flg_seen, flg_stop, flg_ovf;
   logic [3:0]  pay_hi;
   logic        pay_odd;
   logic        pay_bad;

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   task automatic clear_parser();
      field_num = '0; magic_pos = '0; magic_bad = 1'b0;
      type_len = '0; type_ch = '0; id_val = '0; flg_val = '0;
      id_seen = 1'b0; id_stop = 1'b0; id_ovf = 1'b0;
      flg_seen = 1'b0; flg_stop = 1'b0; flg_ovf = 1'b0;
      pay_hi = '0; pay_odd = 1'b0; pay_bad = 1'b0;
   endtask

   // hex number: digits up to the first non-hex character, value frozen on overflow
   task automatic absorb_digit(input logic [7:0] c, inout logic [31:0] val,
                               inout logic seen, inout logic stopped, inout logic ovf);
      int v;
      v = hex_nibble(c);
      if (!stopped) begin
         if (v < 0) begin
            stopped = 1'b1;
         end else begin
            seen = 1'b1;
            if (val[31:28] != 4'd0) ovf = 1'b1;
            if (!ovf) val = {val[27:0], 4'(v)};
         end
      end
   endtask

   task automatic parse_char(input logic [7:0] c, input logic eop);
      int nib;
      logic [2:0] verdict;
      dhpp_pkg::dhpp_result_type beat;
      beat = '0;
      if (c == dhpp_pkg::DELIM_CHAR) begin
         if (field_num != dhpp_pkg::FIELD_MAX) field_num = field_num + 3'd1;
      end else begin
         case (field_num)
            FLD_MAGIC: begin
               if (magic_pos >= dhpp_pkg::MAGIC_LEN) magic_bad = 1'b1;
               else if (MAGIC_WORD[8 * (4 - int'(magic_pos)) +: 8] != c) magic_bad = 1'b1;
               if (magic_pos != dhpp_pkg::MAGIC_SAT) magic_pos = magic_pos + 3'd1;
            end
            FLD_TYPE: begin
               if (type_len == 2'd0) type_ch = c;
               if (type_len != 2'd2) type_len = type_len + 2'd1;
            end
            FLD_SRC: begin
               beat.out_kind = dhpp_pkg::KIND_SRC;
               beat.out_byte = c;
               expected_beats = {expected_beats, beat};
            end
            FLD_DST: begin
               beat.out_kind = dhpp_pkg::KIND_DST;
               beat.out_byte = c;
               expected_beats = {expected_beats, beat};
            end
            FLD_ID:    absorb_digit(c, id_val, id_seen, id_stop, id_ovf);
            FLD_FLAGS: absorb_digit(c, flg_val, flg_seen, flg_stop, flg_ovf);
            FLD_PAYLOAD: begin
               nib = hex_nibble(c);
               if (nib < 0) begin
                  pay_bad = 1'b1;
                  nib = 0;
               end
               if (!pay_odd) begin
                  pay_hi = 4'(nib);
                  pay_odd = 1'b1;
               end else begin
                  beat.out_kind = dhpp_pkg::KIND_PAYLOAD;
                  beat.out_byte = {pay_hi, 4'(nib)};
                  expected_beats = {expected_beats, beat};
                  pay_odd = 1'b0;
               end
            end
            default: ;
         endcase
      end

      if (eop) begin
         if (field_num != dhpp_pkg::FIELD_LAST) verdict = dhpp_pkg::STATUS_FIELDS;
         else if (magic_bad || magic_pos != dhpp_pkg::MAGIC_LEN) verdict = dhpp_pkg::STATUS_MAGIC;
         else if (type_len != 2'd1) verdict = dhpp_pkg::STATUS_TYPELEN;
         else if (!id_seen || id_ovf) verdict = dhpp_pkg::STATUS_ID;
         else if (!flg_seen || flg_ovf || flg_val > dhpp_pkg::FLAGS_MAX)
            verdict = dhpp_pkg::STATUS_FLAGS;
         else if (pay_bad || pay_odd) verdict = dhpp_pkg::STATUS_PAYLOAD;
         else verdict = dhpp_pkg::STATUS_OK;
         beat = '0;
         beat.out_kind = dhpp_pkg::KIND_SUMMARY;
         beat.status = verdict;
         beat.last = 1'b1;
         if (verdict == dhpp_pkg::STATUS_OK) begin
            beat.msg_type = type_ch;
            beat.msg_id = id_val;
            beat.msg_flags = flg_val[7:0];
         end
         expected_beats = {expected_beats, beat};
         clear_parser();
      end
   endtask

   // ---------------- packet generation ----------------

   function automatic logic [7:0] hex_char(input int v);
      if (v < 10) return 8'(int'("0") + v);
      return 8'(($urandom_range(1) ? int'("a") : int'("A")) + v - 10);
   endfunction

   function automatic logic [7:0] stop_char();
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (hex_nibble(c) >= 0 || c == dhpp_pkg::DELIM_CHAR);
      return c;
   endfunction

   task automatic add_byte(input logic [7:0] c);
      packet_chars = {packet_chars, c};
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endtask

   task automatic add_text_chars(input int n);
      logic [7:0] c;
      repeat (n) begin
         do c = 8'($urandom_range(255));
         while (c == dhpp_pkg::DELIM_CHAR);
         add_byte(c);
      end
   endtask

   task automatic add_hex_digits(input int n);
      repeat (n) add_byte(hex_char($urandom_range(15)));
   endtask

   task automatic add_hex_value(input int v, input int digits);
      for (int i = digits - 1; i >= 0; i--) add_byte(hex_char((v >> (4 * i)) & 15));
   endtask

   task automatic close_packet();
      rx_char_type b;
      for (int i = 0; i < packet_chars.size(); i++) begin
         b.ch = packet_chars[i];
         b.eop = (i == packet_chars.size() - 1);
         char_queue = {char_queue, b};
      end
      packet_chars.delete();
   endtask

   task automatic queue_packet();
      int fault, n, v, pos;
      int bars[$];
      string magic;
      magic = "CP2P1";
      fault = ($urandom_range(99) < 55) ? FAULT_NONE
                                        : $urandom_range(FAULT_FIELDS_FEW, FAULT_EARLY_EOP);
      if (fault == FAULT_NOISE) begin
         n = $urandom_range(1, 12);
         repeat (n) add_byte(($urandom_range(3) == 0) ? dhpp_pkg::DELIM_CHAR
                                                      : 8'($urandom_range(255)));
         close_packet();
         return;
      end

      if (fault == FAULT_MAGIC) begin
         case ($urandom_range(2))
            0: begin
               add_text(magic);
               pos = $urandom_range(4);
               packet_chars[pos] = packet_chars[pos] ^ 8'h20;
            end
            1: begin
               n = $urandom_range(4);
               for (int i = 0; i < n; i++) add_byte(magic[i]);
            end
            default: begin
               add_text(magic);
               add_text_chars(1);
            end
         endcase
      end else begin
         add_text(magic);
      end
      add_byte(dhpp_pkg::DELIM_CHAR);

      if (fault == FAULT_TYPE) add_text_chars($urandom_range(1) ? 0 : $urandom_range(2, 3));
      else add_text_chars(1);
      add_byte(dhpp_pkg::DELIM_CHAR);
      add_text_chars($urandom_range(3));
      add_byte(dhpp_pkg::DELIM_CHAR);
      add_text_chars($urandom_range(3));
      add_byte(dhpp_pkg::DELIM_CHAR);

      case (fault)
         FAULT_ID_EMPTY: begin
            if ($urandom_range(1)) begin
               add_byte(stop_char());
               add_hex_digits($urandom_range(2));
            end
         end
         FAULT_ID_OVERFLOW: begin
            add_byte(hex_char($urandom_range(1, 15)));
            add_hex_digits($urandom_range(8, 9));
         end
         default: begin
            // leading zeros never overflow
            if ($urandom_range(4) == 0) repeat ($urandom_range(1, 6)) add_byte("0");
            add_hex_digits($urandom_range(1, 8));
            if ($urandom_range(3) == 0) begin
               add_byte(stop_char());
               add_text_chars($urandom_range(3));
            end
         end
      endcase
      add_byte(dhpp_pkg::DELIM_CHAR);

      case (fault)
         FAULT_FLAGS_BIG: begin
            if ($urandom_range(1)) begin
               add_hex_value($urandom_range(256, 65535), 4);
            end else begin
               add_byte(hex_char($urandom_range(1, 15)));
               add_hex_digits(8);
            end
         end
         FAULT_FLAGS_EMPTY: begin
            if ($urandom_range(1)) begin
               add_byte(stop_char());
               add_hex_digits($urandom_range(2));
            end
         end
         default: begin
            v = $urandom_range(255);
            repeat ($urandom_range(2)) add_byte("0");
            add_hex_value(v, (v < 16 && $urandom_range(1)) ? 1 : 2);
            if ($urandom_range(3) == 0) begin
               add_byte(stop_char());
               add_text_chars($urandom_range(3));
            end
         end
      endcase
      add_byte(dhpp_pkg::DELIM_CHAR);

      case (fault)
         FAULT_PAYLOAD_ODD: add_hex_digits(2 * $urandom_range(2) + 1);
         FAULT_PAYLOAD_BAD: begin
            n = 2 * $urandom_range(1, 3);
            add_hex_digits(n);
            packet_chars[packet_chars.size() - 1 - $urandom_range(n - 1)] = stop_char();
         end
         default: add_hex_digits(2 * $urandom_range(3));
      endcase

      case (fault)
         FAULT_FIELDS_MANY: begin
            add_byte(dhpp_pkg::DELIM_CHAR);
            add_text_chars($urandom_range(3));
            if ($urandom_range(1)) begin
               add_byte(dhpp_pkg::DELIM_CHAR);
               add_text_chars($urandom_range(2));
            end
         end
         FAULT_FIELDS_FEW: begin
            for (int i = 0; i < packet_chars.size(); i++)
               if (packet_chars[i] == dhpp_pkg::DELIM_CHAR) bars = {bars, i};
            packet_chars.delete(bars[$urandom_range(bars.size() - 1)]);
         end
         FAULT_EARLY_EOP: begin
            n = $urandom_range(1, packet_chars.size() - 1);
            while (packet_chars.size() > n) void'(packet_chars.pop_back());
         end
         default: ;
      endcase
      close_packet();
   endtask

   // waits at the falling edge, clear of the clocked processes
   task automatic run_phase(input int idle_pct, input int stall_pct, input int chars,
                            input bit hold);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      if (hold) hold_requests = hold_requests + 1;
      while (char_queue.size() < chars) queue_packet();
      while (char_queue.size() != 0 || req_valid || expected_beats.size() != 0)
         @(negedge clock);
   endtask

   // ---------------- driver ----------------

   always @(posedge clock) begin : drive
      rx_char_type next_char;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) parse_char(req_rx_byte, req_end_of_packet);
         if (char_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            next_char = char_queue.pop_front();
            req_valid <= 1'b1;
            req_rx_byte <= next_char.ch;
            req_end_of_packet <= next_char.eop;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count = mismatch_count + 1;
      end
   endtask

   always @(posedge clock) begin : observe
      dhpp_pkg::dhpp_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat expected none actual kind %0d byte %0h status %0d",
                        $time, rsp_out_kind, rsp_out_byte, rsp_status);
               mismatch_count = mismatch_count + 1;
            end else begin
               want = expected_beats.pop_front();
               compare_field("out_kind", 32'(want.out_kind), 32'(rsp_out_kind));
               compare_field("out_byte", 32'(want.out_byte), 32'(rsp_out_byte));
               compare_field("msg_type", 32'(want.msg_type), 32'(rsp_msg_type));
               compare_field("msg_id", want.msg_id, rsp_msg_id);
               compare_field("msg_flags", 32'(want.msg_flags), 32'(rsp_msg_flags));
               compare_field("status", 32'(want.status), 32'(rsp_status));
               compare_field("last", 32'(want.last), 32'(rsp_last));
            end
         end
         // long hold-off: the queue fills and the sender sees req_stall
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
         end
      end
   end

   // ---------------- watchdog ----------------

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------- sequence ----------------

   initial begin
      clear_parser();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // extreme characters and values in one good packet, then lone one-beat packets
      add_text("CP2P1|");
      add_byte(8'hFF);
      add_byte(dhpp_pkg::DELIM_CHAR);
      add_byte(8'h00);
      add_byte(dhpp_pkg::DELIM_CHAR);
      add_byte(8'hFE);
      add_text("|FFFFFFFF|FF|00fF");
      close_packet();
      add_byte(dhpp_pkg::DELIM_CHAR);
      close_packet();
      add_byte(8'h00);
      close_packet();
      run_phase(0, 0, 0, 1'b0);

      run_phase(0, 0, 110, 1'b1);
      run_phase(81, 0, 110, 1'b0);
      run_phase(0, 81, 110, 1'b0);
      run_phase(34, 34, 110, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
